// ===== hdl/rbst_pkg.sv =====
`default_nettype none
package rbst_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int LANES       = 6;
	localparam int AXES        = 3;
	localparam int QBITS       = 32;
	localparam int STEPS       = 4;
	localparam int DIV_STAGES  = QBITS / STEPS;
	localparam int MAG_W       = 33;
	localparam int NUM_W       = MAG_W + FRAC_BITS;
	localparam int TOP_W       = NUM_W - QBITS;
	localparam int IN_W        = 448;

	typedef logic signed [31:0] fx_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] zero;
		fx_t        tmin;
		fx_t        tmax;
	} side_t;

endpackage
`default_nettype wire

// ===== hdl/ray_box_slab_test.sv =====
`default_nettype none
// An accepted item runs through stages 1 to 14 and the output register.
// Throughput: one item per cycle while the output is not stalled; six lanes of a
// 32-quotient-bit restoring divider, four quotient bits per register stage over eight stages, set the depth.
// A stall at the output holds every stage in place.
// Reset clears the valid bits of all stages; data registers are not reset.
module ray_box_slab_test
	import rbst_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_lo_x, box_lo_y,
	// box_lo_z, box_hi_x, box_hi_y, box_hi_z, tmin, tmax
	input  wire logic [IN_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	// hit, then zero fill
	output logic [7:0]           m_tdata
);

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: input capture
	logic  v_s1;
	fx_t   org_s1 [AXES];
	fx_t   dir_s1 [AXES];
	fx_t   lo_s1  [AXES];
	fx_t   hi_s1  [AXES];
	fx_t   tmin_s1, tmax_s1;

	// stage 2: magnitudes and flags
	logic             v_s2;
	logic [NUM_W-1:0] num_s2 [LANES];
	logic [31:0]      den_s2 [LANES];
	logic             neg_s2 [LANES];
	side_t            side_s2;

	// stage 3: overflow and divider set-up
	logic        v_s3;
	logic [31:0] rem_s3 [LANES];
	logic [31:0] nlo_s3 [LANES];
	logic [31:0] den_s3 [LANES];
	logic        neg_s3 [LANES];
	logic        ovf_s3 [LANES];
	side_t       side_s3;

	// divider stages
	logic        dv_v_s                 [DIV_STAGES];
	logic [31:0] dv_rem_s  [DIV_STAGES] [LANES];
	logic [31:0] dv_quo_s  [DIV_STAGES] [LANES];
	logic [31:0] dv_nlo_s  [DIV_STAGES] [LANES];
	logic [31:0] dv_den_s  [DIV_STAGES] [LANES];
	logic        dv_neg_s  [DIV_STAGES] [LANES];
	logic        dv_ovf_s  [DIV_STAGES] [LANES];
	side_t       dv_side_s [DIV_STAGES];

	logic [31:0] nx_rem [DIV_STAGES] [LANES];
	logic [31:0] nx_quo [DIV_STAGES] [LANES];
	logic [31:0] nx_nlo [DIV_STAGES] [LANES];

	// stage 12: saturated slab distances
	logic  v_s12;
	fx_t   t_s12 [LANES];
	side_t side_s12;

	// stage 13: per-axis ordering
	logic  v_s13;
	fx_t   near_s13 [AXES];
	fx_t   far_s13  [AXES];
	side_t side_s13;

	// stage 14: narrowed interval
	logic v_s14;
	logic ok_s14;
	fx_t  tmin_s14, tmax_s14;

	logic hit_q;

	always_comb begin
		logic [32:0] t;
		logic [31:0] r, q, n, d;
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int l = 0; l < LANES; l++) begin
				if (k == 0) begin
					r = rem_s3[l];
					q = '0;
					n = nlo_s3[l];
					d = den_s3[l];
				end else begin
					r = dv_rem_s[k-1][l];
					q = dv_quo_s[k-1][l];
					n = dv_nlo_s[k-1][l];
					d = dv_den_s[k-1][l];
				end
				for (int j = 0; j < STEPS; j++) begin
					t = {r, n[31]};
					n = {n[30:0], 1'b0};
					if (t >= {1'b0, d}) begin
						t = t - {1'b0, d};
						q = {q[30:0], 1'b1};
					end else begin
						q = {q[30:0], 1'b0};
					end
					r = t[31:0];
				end
				nx_rem[k][l] = r;
				nx_quo[k][l] = q;
				nx_nlo[k][l] = n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			m_tvalid <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) begin
				dv_v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			dv_v_s[0] <= v_s3;
			for (int k = 1; k < DIV_STAGES; k++) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
			v_s12 <= dv_v_s[DIV_STAGES-1];
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			m_tvalid <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [32:0] diff;
		logic [32:0]        mag;
		fx_t                bnd;
		logic [31:0]        qm;
		fx_t                tn, tf, mn, mx;
		if (adv) begin
			// stage 1
			for (int a = 0; a < AXES; a++) begin
				org_s1[a] <= s_tdata[32*a +: 32];
				dir_s1[a] <= s_tdata[96 + 32*a +: 32];
				lo_s1[a]  <= s_tdata[192 + 32*a +: 32];
			end
			hi_s1[0] <= s_tdata[319:288];
			hi_s1[1] <= s_tdata[351:320];
			hi_s1[2] <= s_tdata[383:352];
			tmin_s1  <= s_tdata[415:384];
			tmax_s1  <= s_tdata[447:416];

			// stage 2
			for (int l = 0; l < LANES; l++) begin
				bnd  = (l % 2 == 0) ? lo_s1[l/2] : hi_s1[l/2];
				diff = 33'(signed'(bnd)) - 33'(signed'(org_s1[l/2]));
				mag  = diff[32] ? 33'(-diff) : 33'(diff);
				num_s2[l] <= {mag, {FRAC_BITS{1'b0}}};
				den_s2[l] <= dir_s1[l/2][31] ? 32'(-dir_s1[l/2]) : 32'(dir_s1[l/2]);
				neg_s2[l] <= diff[32] ^ dir_s1[l/2][31];
			end
			side_s2.ok <= !(lo_s1[0] == 0 && lo_s1[1] == 0 && lo_s1[2] == 0 &&
				hi_s1[0] == 0 && hi_s1[1] == 0 && hi_s1[2] == 0) &&
				!(dir_s1[0] == 0 && (org_s1[0] < lo_s1[0] || org_s1[0] > hi_s1[0])) &&
				!(dir_s1[1] == 0 && (org_s1[1] < lo_s1[1] || org_s1[1] > hi_s1[1])) &&
				!(dir_s1[2] == 0 && (org_s1[2] < lo_s1[2] || org_s1[2] > hi_s1[2]));
			for (int a = 0; a < AXES; a++) begin
				side_s2.zero[a] <= (dir_s1[a] == 0);
			end
			side_s2.tmin <= tmin_s1;
			side_s2.tmax <= tmax_s1;

			// stage 3
			for (int l = 0; l < LANES; l++) begin
				ovf_s3[l] <= {{(33-TOP_W){1'b0}}, num_s2[l][NUM_W-1:QBITS]} >=
					{1'b0, den_s2[l]};
				rem_s3[l] <= {{(32-TOP_W){1'b0}}, num_s2[l][NUM_W-1:QBITS]};
				nlo_s3[l] <= num_s2[l][QBITS-1:0];
				den_s3[l] <= den_s2[l];
				neg_s3[l] <= neg_s2[l];
			end
			side_s3 <= side_s2;

			// divider
			for (int k = 0; k < DIV_STAGES; k++) begin
				for (int l = 0; l < LANES; l++) begin
					dv_rem_s[k][l] <= nx_rem[k][l];
					dv_quo_s[k][l] <= nx_quo[k][l];
					dv_nlo_s[k][l] <= nx_nlo[k][l];
					dv_den_s[k][l] <= (k == 0) ? den_s3[l] : dv_den_s[k-1][l];
					dv_neg_s[k][l] <= (k == 0) ? neg_s3[l] : dv_neg_s[k-1][l];
					dv_ovf_s[k][l] <= (k == 0) ? ovf_s3[l] : dv_ovf_s[k-1][l];
				end
				dv_side_s[k] <= (k == 0) ? side_s3 : dv_side_s[k-1];
			end

			// stage 12: sign and saturation
			for (int l = 0; l < LANES; l++) begin
				qm = dv_quo_s[DIV_STAGES-1][l];
				if (!dv_neg_s[DIV_STAGES-1][l]) begin
					t_s12[l] <= (dv_ovf_s[DIV_STAGES-1][l] || qm[31]) ?
						32'h7fff_ffff : qm;
				end else begin
					t_s12[l] <= (dv_ovf_s[DIV_STAGES-1][l] || qm > 32'h8000_0000) ?
						32'h8000_0000 : 32'(-qm);
				end
			end
			side_s12 <= dv_side_s[DIV_STAGES-1];

			// stage 13
			for (int a = 0; a < AXES; a++) begin
				tn = t_s12[2*a];
				tf = t_s12[2*a+1];
				near_s13[a] <= (tn < tf) ? tn : tf;
				far_s13[a]  <= (tn < tf) ? tf : tn;
			end
			side_s13 <= side_s12;

			// stage 14
			mn = side_s13.tmin;
			mx = side_s13.tmax;
			for (int a = 0; a < AXES; a++) begin
				if (!side_s13.zero[a]) begin
					if (near_s13[a] > mn) mn = near_s13[a];
					if (far_s13[a] < mx) mx = far_s13[a];
				end
			end
			tmin_s14 <= mn;
			tmax_s14 <= mx;
			ok_s14   <= side_s13.ok;

			hit_q <= ok_s14 && (tmax_s14 > tmin_s14);
		end
	end

	assign m_tdata = {7'b0, hit_q};

`ifndef SYNTH
	a_miss_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s14 && !ok_s14 |=> !m_tdata[0])
		else $error("degenerate or out-of-slab item reported as hit");

	a_out_from_s14: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s14))
		else $error("result without an item in the last stage");

	a_div_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> dv_v_s[0])
		else $error("item lost entering the divider");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import rbst_pkg::*;

	typedef struct {
		logic signed [31:0] org [3];
		logic signed [31:0] dir [3];
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		logic signed [31:0] t_in;
		logic signed [31:0] t_out;
	} ray_box_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;

	logic hit_q [$];
	int errors;
	int src_idle_pct;
	int dst_stall_pct;

	ray_box_slab_test uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic signed [31:0] slab_dist(longint diff, longint d);
		longint q;
		q = (diff * 65536) / d;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic logic predict_hit(ray_box_t r);
		longint tmin, tmax, d0, d1, t0, t1;
		logic h;
		h = 1'b1;
		tmin = r.t_in;
		tmax = r.t_out;
		if (r.lo[0] == 0 && r.lo[1] == 0 && r.lo[2] == 0 &&
				r.hi[0] == 0 && r.hi[1] == 0 && r.hi[2] == 0)
			h = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (h) begin
				if (r.dir[a] == 0) begin
					if (r.org[a] < r.lo[a] || r.org[a] > r.hi[a])
						h = 1'b0;
				end else begin
					d0 = slab_dist(longint'(r.lo[a]) - r.org[a], r.dir[a]);
					d1 = slab_dist(longint'(r.hi[a]) - r.org[a], r.dir[a]);
					t0 = d0 < d1 ? d0 : d1;
					t1 = d0 < d1 ? d1 : d0;
					if (t0 > tmin)
						tmin = t0;
					if (t1 < tmax)
						tmax = t1;
					if (tmax <= tmin)
						h = 1'b0;
				end
			end
		end
		if (tmax <= tmin)
			h = 1'b0;
		return h;
	endfunction

	function automatic logic [IN_W-1:0] pack_ray(ray_box_t r);
		return {r.t_out, r.t_in, r.hi[2], r.hi[1], r.hi[0], r.lo[2], r.lo[1], r.lo[0],
			r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
	endfunction

	task automatic send_ray(ray_box_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_ray(r);
		hit_q.push_back(predict_hit(r));
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= dst_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (hit_q.size() == 0) begin
				$error("hit: unexpected result %0d", m_tdata[0]);
				errors++;
			end else begin
				logic e;
				e = hit_q.pop_front();
				if (m_tdata[0] !== e || m_tdata[7:1] !== 7'd0) begin
					$error("hit: expected %0d, got %0d", e, m_tdata);
					errors++;
				end
			end
		end
	end

	function automatic logic signed [31:0] rnd_fx(int span);
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'sh8000_0000 + $urandom_range(3);
			2: return 32'sd2147483647 - $urandom_range(3);
			3: return $urandom_range(2);
			default: return $signed($urandom_range(2 * span)) - span;
		endcase
	endfunction

	function automatic ray_box_t rnd_ray();
		ray_box_t r;
		int s;
		s = 32'h0008_0000;
		for (int a = 0; a < 3; a++) begin
			r.org[a] = ($urandom_range(9) == 0) ? rnd_fx(s) : $signed($urandom_range(2 * s)) - s;
			r.dir[a] = ($urandom_range(7) == 0) ? 0 : rnd_fx(s);
			r.lo[a] = ($urandom_range(9) == 0) ? rnd_fx(s) : $signed($urandom_range(s)) - s;
			r.hi[a] = ($urandom_range(9) == 0) ? rnd_fx(s) : $signed($urandom_range(s));
		end
		r.t_in = ($urandom_range(3) == 0) ? rnd_fx(s) : 0;
		r.t_out = ($urandom_range(3) == 0) ? rnd_fx(s) : 32'sh7fff_ffff;
		return r;
	endfunction

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (hit_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		ray_box_t r, b;
		for (int a = 0; a < 3; a++) begin
			b.org[a] = 0;
			b.dir[a] = 32'sh0001_0000;
			b.lo[a] = 32'sh0001_0000;
			b.hi[a] = 32'sh0002_0000;
		end
		b.t_in = 0;
		b.t_out = 32'sh7fff_ffff;
		send_ray(b);
		r = b;
		for (int a = 0; a < 3; a++) begin
			r.lo[a] = 0;
			r.hi[a] = 0;
		end
		send_ray(r);
		r = b;
		r.dir[1] = 0;
		send_ray(r);
		r.org[1] = 32'sh0001_0000;
		send_ray(r);
		r.org[1] = 32'sh0002_0000;
		send_ray(r);
		r.lo[1] = 32'sh0003_0000;
		send_ray(r);
		r = b;
		r.lo[0] = 32'sh0002_0000;
		r.hi[0] = 32'sh0001_0000;
		send_ray(r);
		r = b;
		r.t_in = 32'sh0005_0000;
		r.t_out = 32'sh0005_0000;
		send_ray(r);
		r = b;
		r.dir[2] = 1;
		r.hi[2] = 32'sh7fff_ffff;
		r.org[2] = 32'sh8000_0000;
		send_ray(r);
		r.dir[2] = -1;
		send_ray(r);
		r.dir[2] = 32'sh8000_0000;
		send_ray(r);
		r = b;
		for (int a = 0; a < 3; a++) begin
			r.org[a] = 32'sh7fff_ffff;
			r.dir[a] = 32'sh7fff_ffff;
			r.lo[a] = 32'sh8000_0000;
			r.hi[a] = 32'sh7fff_ffff;
		end
		r.t_in = 32'sh8000_0000;
		send_ray(r);
		r = b;
		for (int a = 0; a < 3; a++)
			r.dir[a] = -32'sh0001_0000;
		send_ray(r);
		r.t_in = -32'sh0005_0000;
		r.t_out = -32'sh0001_0000;
		send_ray(r);
		wait_drain();
	endtask

	task automatic test_random(int n, int idle, int stall);
		src_idle_pct = idle;
		dst_stall_pct = stall;
		for (int i = 0; i < n; i++)
			send_ray(rnd_ray());
	endtask

	task automatic test_pause();
		src_idle_pct = 0;
		dst_stall_pct = 30;
		for (int i = 0; i < 20; i++)
			send_ray(rnd_ray());
		wait_drain();
		for (int i = 0; i < 20; i++)
			send_ray(rnd_ray());
	endtask

	initial begin
		errors = 0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400, 0, 0);
		test_random(400, 73, 0);
		test_random(400, 0, 73);
		test_random(400, 30, 30);
		test_pause();
		fork
			wait_drain();
			begin
				repeat (20000) @(posedge clk);
			end
		join_any
		disable fork;
		repeat (30) @(posedge clk);
		if (errors == 0 && hit_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
